// File: rtl/gpio_pkg.sv
package gpio_pkg;

    localparam int PORTS = 4;
    localparam int LINES = 16;
    localparam int PIN_W = PORTS * 16;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_SPARE  = 2'd3
    } req_t;

    localparam logic [2:0] BLK_EXTI = 3'd4;

    // port register offsets
    localparam logic [7:0] OFF_MODE  = 8'h00;
    localparam logic [7:0] OFF_OTYPE = 8'h04;
    localparam logic [7:0] OFF_SPEED = 8'h08;
    localparam logic [7:0] OFF_PULL  = 8'h0c;
    localparam logic [7:0] OFF_IDR   = 8'h10;
    localparam logic [7:0] OFF_ODR   = 8'h14;
    localparam logic [7:0] OFF_BSRR  = 8'h18;
    localparam logic [7:0] OFF_AFL   = 8'h20;
    localparam logic [7:0] OFF_AFH   = 8'h24;

    // interrupt unit offsets
    localparam logic [7:0] OFF_RTSR  = 8'h00;
    localparam logic [7:0] OFF_FTSR  = 8'h04;
    localparam logic [7:0] OFF_RPR   = 8'h0c;
    localparam logic [7:0] OFF_FPR   = 8'h10;
    localparam logic [7:0] OFF_CR0   = 8'h60;
    localparam logic [7:0] OFF_CR1   = 8'h64;
    localparam logic [7:0] OFF_CR2   = 8'h68;
    localparam logic [7:0] OFF_CR3   = 8'h6c;
    localparam logic [7:0] OFF_IMR   = 8'h80;

endpackage

// File: rtl/gpio_ports_with_edge_interrupts_core.sv
// Channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall   | req_type, block_sel, reg_offset,
//         |           |                     | write_data, pin_levels
// out     | out       | out_valid/out_stall | read_data, pin_drive,
//         |           |                     | pin_drive_enable, irq_groups
// One item per cycle unless stalled; a result appears in the cycle after its item is accepted.
// All register state updates at the acceptance edge, results are registered.
// A stalled result holds in the output register; input is stalled only while
// a held result waits, so the output register is the one slot of latency.
// rst_n async-resets all but output data registers to their documented values.
module gpio_ports_with_edge_interrupts_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [2:0]  block_sel,
    input  logic [7:0]  reg_offset,
    input  logic [31:0] write_data,
    input  logic [63:0] pin_levels,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [63:0] pin_drive,
    output logic [63:0] pin_drive_enable,
    output logic [2:0]  irq_groups
);

    localparam int P = gpio_pkg::PORTS;
    localparam int L = gpio_pkg::LINES;

    logic [31:0] mode_reg   [P];
    logic [15:0] otype_reg  [P];
    logic [31:0] speed_reg  [P];
    logic [31:0] pull_reg   [P];
    logic [15:0] odr_reg    [P];
    logic [63:0] af_reg     [P];
    logic [15:0] rise_en_reg, fall_en_reg, rise_pend_reg, fall_pend_reg;
    logic [15:0] mask_reg, prev_reg;
    logic [1:0]  sel_reg    [L];

    logic [15:0] rise_pend_next, fall_pend_next, now_lvl;
    logic [15:0] odr_next   [P];
    logic [31:0] mode_next  [P];
    logic [15:0] otype_next [P];

    logic        accept;
    logic        is_rd, is_wr, port_ok, exti_sel;
    logic [1:0]  pidx;
    logic [31:0] rd_next;
    logic [63:0] drive_next, en_next;
    logic [15:0] pend_next;

    logic        out_valid_reg;
    logic [31:0] rd_reg;
    logic [63:0] drive_reg, en_reg;
    logic [2:0]  irq_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_rd    = (gpio_pkg::req_t'(req_type) == gpio_pkg::REQ_READ);
    assign is_wr    = (gpio_pkg::req_t'(req_type) == gpio_pkg::REQ_WRITE);
    assign port_ok  = ({29'd0, block_sel} < P);
    assign exti_sel = (block_sel == gpio_pkg::BLK_EXTI);
    assign pidx     = block_sel[1:0];

    // sample line levels from the selected port
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            now_lvl[i] = ({30'd0, sel_reg[i]} < P) ?
                pin_levels[{sel_reg[i], 4'(i)}] : 1'b0;
        end
    end

    // record edges, then apply write-one-to-clear
    always_comb
    begin
        rise_pend_next = rise_pend_reg | (now_lvl & ~prev_reg & rise_en_reg);
        fall_pend_next = fall_pend_reg | (prev_reg & ~now_lvl & fall_en_reg);
        if (is_wr && exti_sel && reg_offset == gpio_pkg::OFF_RPR)
            rise_pend_next = rise_pend_next & ~write_data[15:0];
        if (is_wr && exti_sel && reg_offset == gpio_pkg::OFF_FPR)
            fall_pend_next = fall_pend_next & ~write_data[15:0];
    end

    // next port output state, used for the registered outputs
    always_comb
    begin
        for (int p = 0; p < P; p++)
        begin
            odr_next[p]   = odr_reg[p];
            mode_next[p]  = mode_reg[p];
            otype_next[p] = otype_reg[p];
            if (is_wr && port_ok && pidx == 2'(p))
            begin
                case (reg_offset)
                    gpio_pkg::OFF_MODE:  mode_next[p]  = write_data;
                    gpio_pkg::OFF_OTYPE: otype_next[p] = write_data[15:0];
                    gpio_pkg::OFF_ODR:   odr_next[p]   = write_data[15:0];
                    gpio_pkg::OFF_BSRR:  odr_next[p]   =
                        (odr_reg[p] & ~write_data[31:16]) | write_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // read mux, values as seen after this item's pin sample
    always_comb
    begin
        rd_next = '0;
        if (is_rd && port_ok)
        begin
            unique case (reg_offset)
                gpio_pkg::OFF_MODE:  rd_next = mode_reg[pidx];
                gpio_pkg::OFF_OTYPE: rd_next = {16'd0, otype_reg[pidx]};
                gpio_pkg::OFF_SPEED: rd_next = speed_reg[pidx];
                gpio_pkg::OFF_PULL:  rd_next = pull_reg[pidx];
                gpio_pkg::OFF_IDR:   rd_next = {16'd0, pin_levels[{pidx, 4'd0} +: 16]};
                gpio_pkg::OFF_ODR:   rd_next = {16'd0, odr_reg[pidx]};
                gpio_pkg::OFF_AFL:   rd_next = af_reg[pidx][31:0];
                gpio_pkg::OFF_AFH:   rd_next = af_reg[pidx][63:32];
                default:             rd_next = '0;
            endcase
        end
        else if (is_rd && exti_sel)
        begin
            unique case (reg_offset)
                gpio_pkg::OFF_RTSR: rd_next = {16'd0, rise_en_reg};
                gpio_pkg::OFF_FTSR: rd_next = {16'd0, fall_en_reg};
                gpio_pkg::OFF_RPR:  rd_next = {16'd0, rise_pend_next};
                gpio_pkg::OFF_FPR:  rd_next = {16'd0, fall_pend_next};
                gpio_pkg::OFF_CR0:  rd_next = {6'd0, sel_reg[3], 6'd0, sel_reg[2],
                                               6'd0, sel_reg[1], 6'd0, sel_reg[0]};
                gpio_pkg::OFF_CR1:  rd_next = {6'd0, sel_reg[7], 6'd0, sel_reg[6],
                                               6'd0, sel_reg[5], 6'd0, sel_reg[4]};
                gpio_pkg::OFF_CR2:  rd_next = {6'd0, sel_reg[11], 6'd0, sel_reg[10],
                                               6'd0, sel_reg[9], 6'd0, sel_reg[8]};
                gpio_pkg::OFF_CR3:  rd_next = {6'd0, sel_reg[15], 6'd0, sel_reg[14],
                                               6'd0, sel_reg[13], 6'd0, sel_reg[12]};
                gpio_pkg::OFF_IMR:  rd_next = {16'd0, mask_reg};
                default:            rd_next = '0;
            endcase
        end
    end

    // drive and enable per pin, interrupt groups
    always_comb
    begin
        logic [15:0] msk;
        msk = mask_reg;
        if (is_wr && exti_sel && reg_offset == gpio_pkg::OFF_IMR)
            msk = write_data[15:0];
        drive_next = '0;
        en_next    = '0;
        for (int p = 0; p < P; p++)
        begin
            drive_next[16*p +: 16] = odr_next[p];
            for (int i = 0; i < 16; i++)
            begin
                en_next[16*p + i] = (mode_next[p][2*i +: 2] == 2'b01) &&
                    (!otype_next[p][i] || !odr_next[p][i]);
            end
        end
        pend_next = (rise_pend_next | fall_pend_next) & msk;
    end

    // port register file; input data always reads the live pins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < P; p++)
            begin
                mode_reg[p]  <= '1;
                otype_reg[p] <= '0;
                speed_reg[p] <= '0;
                pull_reg[p]  <= '0;
                odr_reg[p]   <= '0;
                af_reg[p]    <= '0;
            end
        end
        else if (accept)
        begin
            for (int p = 0; p < P; p++)
            begin
                mode_reg[p]  <= mode_next[p];
                otype_reg[p] <= otype_next[p];
                odr_reg[p]   <= odr_next[p];
                if (is_wr && port_ok && pidx == 2'(p))
                begin
                    case (reg_offset)
                        gpio_pkg::OFF_SPEED: speed_reg[p]     <= write_data;
                        gpio_pkg::OFF_PULL:  pull_reg[p]      <= write_data;
                        gpio_pkg::OFF_AFL:   af_reg[p][31:0]  <= write_data;
                        gpio_pkg::OFF_AFH:   af_reg[p][63:32] <= write_data;
                        default: ;
                    endcase
                end
            end
        end
    end

    // interrupt unit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_en_reg   <= '0;
            fall_en_reg   <= '0;
            rise_pend_reg <= '0;
            fall_pend_reg <= '0;
            mask_reg      <= '0;
            prev_reg      <= '0;
            for (int i = 0; i < L; i++)
                sel_reg[i] <= '0;
        end
        else if (accept)
        begin
            rise_pend_reg <= rise_pend_next;
            fall_pend_reg <= fall_pend_next;
            prev_reg      <= now_lvl;
            if (is_wr && exti_sel)
            begin
                case (reg_offset)
                    gpio_pkg::OFF_RTSR: rise_en_reg <= write_data[15:0];
                    gpio_pkg::OFF_FTSR: fall_en_reg <= write_data[15:0];
                    gpio_pkg::OFF_IMR:  mask_reg    <= write_data[15:0];
                    gpio_pkg::OFF_CR0, gpio_pkg::OFF_CR1,
                    gpio_pkg::OFF_CR2, gpio_pkg::OFF_CR3:
                    begin
                        for (int k = 0; k < 4; k++)
                            sel_reg[{reg_offset[3:2], 2'(k)}] <= write_data[8*k +: 2];
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_next;
            drive_reg <= drive_next;
            en_reg    <= en_next;
            irq_reg   <= {|pend_next[15:4], |pend_next[3:2], |pend_next[1:0]};
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rd_reg;
    assign pin_drive        = drive_reg;
    assign pin_drive_enable = en_reg;
    assign irq_groups       = irq_reg;

`ifndef SYNTH
    // a held result blocks new input
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted over a held result");

    // an accepted item always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item produced no result");

    // a rising pending bit on line 0 never appears without its enable
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rise_pend_reg[0]) |-> $past(rise_en_reg[0]))
        else $error("rise pending set without enable");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [2:0]  block_sel;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [63:0] pin_levels;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic [63:0] pin_drive;
    logic [63:0] pin_drive_enable;
    logic [2:0]  irq_groups;

    typedef struct packed {
        logic [31:0] rdata;
        logic [63:0] drive;
        logic [63:0] drive_en;
        logic [2:0]  irq;
    } gpio_result_t;

    gpio_result_t expected_results[$];
    int           error_count;
    int           idle_cycles;

    // shadow copy of the block's register state
    logic [31:0] sh_mode[4];
    logic [15:0] sh_otype[4];
    logic [31:0] sh_speed[4];
    logic [31:0] sh_pull[4];
    logic [15:0] sh_odr[4];
    logic [63:0] sh_af[4];
    logic [15:0] sh_idr[4];
    logic [15:0] sh_rise_en;
    logic [15:0] sh_fall_en;
    logic [15:0] sh_rise_pend;
    logic [15:0] sh_fall_pend;
    logic [15:0] sh_mask;
    logic [1:0]  sh_line_port[16];
    logic [15:0] sh_prev_level;

    gpio_ports_with_edge_interrupts_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .block_sel        (block_sel),
        .reg_offset       (reg_offset),
        .write_data       (write_data),
        .pin_levels       (pin_levels),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .pin_drive        (pin_drive),
        .pin_drive_enable (pin_drive_enable),
        .irq_groups       (irq_groups)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic reset_shadow();
        for (int p = 0; p < 4; p++)
        begin
            sh_mode[p]  = '1;
            sh_otype[p] = '0;
            sh_speed[p] = '0;
            sh_pull[p]  = '0;
            sh_odr[p]   = '0;
            sh_af[p]    = '0;
            sh_idr[p]   = '0;
        end
        for (int i = 0; i < 16; i++)
            sh_line_port[i] = '0;
        sh_rise_en    = '0;
        sh_fall_en    = '0;
        sh_rise_pend  = '0;
        sh_fall_pend  = '0;
        sh_mask       = '0;
        sh_prev_level = '0;
    endtask

    function automatic logic [31:0] port_reg_value(int p, logic [7:0] off);
        case (off)
            gpio_pkg::OFF_MODE:  return sh_mode[p];
            gpio_pkg::OFF_OTYPE: return {16'h0, sh_otype[p]};
            gpio_pkg::OFF_SPEED: return sh_speed[p];
            gpio_pkg::OFF_PULL:  return sh_pull[p];
            gpio_pkg::OFF_IDR:   return {16'h0, sh_idr[p]};
            gpio_pkg::OFF_ODR:   return {16'h0, sh_odr[p]};
            gpio_pkg::OFF_AFL:   return sh_af[p][31:0];
            gpio_pkg::OFF_AFH:   return sh_af[p][63:32];
            default:             return '0;
        endcase
    endfunction

    function automatic logic [31:0] exti_reg_value(logic [7:0] off);
        logic [31:0] r;
        r = '0;
        case (off)
            gpio_pkg::OFF_RTSR: r = {16'h0, sh_rise_en};
            gpio_pkg::OFF_FTSR: r = {16'h0, sh_fall_en};
            gpio_pkg::OFF_RPR:  r = {16'h0, sh_rise_pend};
            gpio_pkg::OFF_FPR:  r = {16'h0, sh_fall_pend};
            gpio_pkg::OFF_IMR:  r = {16'h0, sh_mask};
            gpio_pkg::OFF_CR0, gpio_pkg::OFF_CR1, gpio_pkg::OFF_CR2, gpio_pkg::OFF_CR3:
            begin
                for (int k = 0; k < 4; k++)
                    r[8*k +: 8] = {6'h0, sh_line_port[(off - gpio_pkg::OFF_CR0) + k]};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic port_reg_write(int p, logic [7:0] off, logic [31:0] v);
        case (off)
            gpio_pkg::OFF_MODE:  sh_mode[p] = v;
            gpio_pkg::OFF_OTYPE: sh_otype[p] = v[15:0];
            gpio_pkg::OFF_SPEED: sh_speed[p] = v;
            gpio_pkg::OFF_PULL:  sh_pull[p] = v;
            gpio_pkg::OFF_ODR:   sh_odr[p] = v[15:0];
            gpio_pkg::OFF_BSRR:  sh_odr[p] = (sh_odr[p] & ~v[31:16]) | v[15:0];
            gpio_pkg::OFF_AFL:   sh_af[p][31:0] = v;
            gpio_pkg::OFF_AFH:   sh_af[p][63:32] = v;
            default:             ;
        endcase
    endtask

    task automatic exti_reg_write(logic [7:0] off, logic [31:0] v);
        case (off)
            gpio_pkg::OFF_RTSR: sh_rise_en = v[15:0];
            gpio_pkg::OFF_FTSR: sh_fall_en = v[15:0];
            gpio_pkg::OFF_RPR:  sh_rise_pend &= ~v[15:0];
            gpio_pkg::OFF_FPR:  sh_fall_pend &= ~v[15:0];
            gpio_pkg::OFF_IMR:  sh_mask = v[15:0];
            gpio_pkg::OFF_CR0, gpio_pkg::OFF_CR1, gpio_pkg::OFF_CR2, gpio_pkg::OFF_CR3:
            begin
                for (int k = 0; k < 4; k++)
                    sh_line_port[(off - gpio_pkg::OFF_CR0) + k] = v[8*k +: 2];
            end
            default: ;
        endcase
    endtask

    // compute the result of one access: sample pins, do the bus access, form outputs
    task automatic predict_gpio_access(logic [1:0] rq, logic [2:0] blk, logic [7:0] off,
                                       logic [31:0] wd, logic [63:0] pins);
        gpio_result_t    res;
        logic [15:0]     now;
        logic [15:0]     pend;
        gpio_pkg::req_t  kind;
        kind = gpio_pkg::req_t'(rq);
        res  = '0;
        now  = '0;
        for (int p = 0; p < gpio_pkg::PORTS; p++)
            sh_idr[p] = pins[16*p +: 16];
        for (int i = 0; i < gpio_pkg::LINES; i++)
            if (sh_line_port[i] < gpio_pkg::PORTS)
                now[i] = pins[16*sh_line_port[i] + i];
        sh_rise_pend |= now & ~sh_prev_level & sh_rise_en;
        sh_fall_pend |= sh_prev_level & ~now & sh_fall_en;
        sh_prev_level = now;

        if (kind == gpio_pkg::REQ_READ)
        begin
            if (blk < gpio_pkg::PORTS)
                res.rdata = port_reg_value(blk, off);
            else if (blk == gpio_pkg::BLK_EXTI)
                res.rdata = exti_reg_value(off);
        end
        else if (kind == gpio_pkg::REQ_WRITE)
        begin
            if (blk < gpio_pkg::PORTS)
                port_reg_write(blk, off, wd);
            else if (blk == gpio_pkg::BLK_EXTI)
                exti_reg_write(off, wd);
        end

        for (int p = 0; p < gpio_pkg::PORTS; p++)
        begin
            res.drive[16*p +: 16] = sh_odr[p];
            for (int i = 0; i < 16; i++)
                res.drive_en[16*p + i] = (sh_mode[p][2*i +: 2] == 2'b01)
                    && (!sh_otype[p][i] || !sh_odr[p][i]);
        end
        pend = (sh_rise_pend | sh_fall_pend) & sh_mask;
        res.irq = {|pend[15:4], |pend[3:2], |pend[1:0]};
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // send one beat after a random gap, then hold it until accepted
    task automatic send_access(logic [1:0] rq, logic [2:0] blk, logic [7:0] off,
                               logic [31:0] wd, logic [63:0] pins, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        block_sel  <= blk;
        reg_offset <= off;
        write_data <= wd;
        pin_levels <= pins;
        predict_gpio_access(rq, blk, off, wd, pins);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_offset(logic [2:0] blk);
        logic [7:0] port_offs[10];
        logic [7:0] exti_offs[9];
        port_offs = '{gpio_pkg::OFF_MODE, gpio_pkg::OFF_OTYPE, gpio_pkg::OFF_SPEED,
                      gpio_pkg::OFF_PULL, gpio_pkg::OFF_IDR, gpio_pkg::OFF_ODR,
                      gpio_pkg::OFF_BSRR, gpio_pkg::OFF_AFL, gpio_pkg::OFF_AFH,
                      gpio_pkg::OFF_BSRR};
        exti_offs = '{gpio_pkg::OFF_RTSR, gpio_pkg::OFF_FTSR, gpio_pkg::OFF_RPR,
                      gpio_pkg::OFF_FPR, gpio_pkg::OFF_CR0, gpio_pkg::OFF_CR1,
                      gpio_pkg::OFF_CR2, gpio_pkg::OFF_CR3, gpio_pkg::OFF_IMR};
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        if (blk == gpio_pkg::BLK_EXTI)
            return exti_offs[$urandom_range(0, 8)];
        return port_offs[$urandom_range(0, 9)];
    endfunction

    // directed: extremes, port registers other than speed and pull, unmapped blocks and offsets
    task automatic test_register_map();
        send_access(gpio_pkg::REQ_READ, 3'd0, gpio_pkg::OFF_MODE, '0, '0);
        send_access(gpio_pkg::REQ_WRITE, 3'd0, gpio_pkg::OFF_MODE, 32'h5555_5555, '1);
        send_access(gpio_pkg::REQ_WRITE, 3'd0, gpio_pkg::OFF_OTYPE, 32'hffff_00ff, '0);
        send_access(gpio_pkg::REQ_WRITE, 3'd0, gpio_pkg::OFF_ODR, 32'hffff_f0f0, '1);
        send_access(gpio_pkg::REQ_WRITE, 3'd0, gpio_pkg::OFF_BSRR, 32'h00ff_ff00, '0);
        send_access(gpio_pkg::REQ_WRITE, 3'd3, gpio_pkg::OFF_AFH, 32'hffff_ffff, '1);
        send_access(gpio_pkg::REQ_WRITE, 3'd3, gpio_pkg::OFF_AFL, 32'h1234_5678, '0);
        send_access(gpio_pkg::REQ_READ, 3'd3, gpio_pkg::OFF_AFH, '0, '0);
        send_access(gpio_pkg::REQ_READ, 3'd0, gpio_pkg::OFF_BSRR, '0, '0);
        send_access(gpio_pkg::REQ_WRITE, 3'd1, gpio_pkg::OFF_IDR, '1,
                    64'hdead_beef_cafe_f00d);
        send_access(gpio_pkg::REQ_READ, 3'd1, gpio_pkg::OFF_IDR, '0,
                    64'hdead_beef_cafe_f00d);
        send_access(gpio_pkg::REQ_WRITE, 3'd2, 8'h02, '1, '0);
        send_access(gpio_pkg::REQ_WRITE, 3'd7, gpio_pkg::OFF_MODE, '1, '0);
        send_access(gpio_pkg::REQ_READ, 3'd5, gpio_pkg::OFF_MODE, '0, '0);
        send_access(gpio_pkg::REQ_SPARE, 3'd0, gpio_pkg::OFF_MODE, '1, '1);
        send_access(gpio_pkg::REQ_READ, 3'd2, 8'hfc, '1, '0);
        drain_results();
    endtask

    // directed: edges on every line group, clear in the same beat as an edge
    task automatic test_edge_interrupts();
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_CR1,
                    32'h0302_0103, '0);
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_RTSR,
                    32'hffff_ffff, '0);
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_FTSR,
                    32'h0000_ffff, '0);
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_IMR,
                    32'hffff_ffff, '0);
        send_access(gpio_pkg::REQ_SAMPLE, 3'd0, gpio_pkg::OFF_MODE, '0, '1);
        send_access(gpio_pkg::REQ_READ, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_RPR, '0, '1);
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_RPR, '1, '0);
        send_access(gpio_pkg::REQ_WRITE, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_FPR, '1, '1);
        send_access(gpio_pkg::REQ_READ, gpio_pkg::BLK_EXTI, gpio_pkg::OFF_CR1, '0, '1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [63:0] pins;
        logic [2:0]  blk;
        logic [1:0]  rq;
        pins = {$urandom, $urandom};
        for (int n = 0; n < 1500; n++)
        begin
            // mostly small pin changes so edges stay sparse enough to observe
            if ($urandom_range(0, 3) == 0)
                pins = {$urandom, $urandom};
            else
                pins ^= 64'(1) << $urandom_range(0, 63);
            rq  = ($urandom_range(0, 19) == 0) ? gpio_pkg::REQ_SPARE
                                               : 2'($urandom_range(0, 2));
            blk = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_access(rq, blk, pick_offset(blk), $urandom, pins,
                        ($urandom_range(0, 3) == 0));
            // at one point hold off until every result has arrived
            if (n == 700)
                drain_results();
        end
        drain_results();
    endtask

    // result side: random stall per beat, compare with the oldest prediction
    initial
    begin
        gpio_result_t want;
        int           stall_left;
        out_stall <= 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 64'd1, 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.rdata)
                        report_mismatch("read_data", 64'(read_data), 64'(want.rdata));
                    if (pin_drive !== want.drive)
                        report_mismatch("pin_drive", pin_drive, want.drive);
                    if (pin_drive_enable !== want.drive_en)
                        report_mismatch("pin_drive_enable", pin_drive_enable,
                                        want.drive_en);
                    if (irq_groups !== want.irq)
                        report_mismatch("irq_groups", 64'(irq_groups), 64'(want.irq));
                end
                // draw the wait before the next beat
                stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
                out_stall <= (stall_left > 0);
            end
            else if (out_stall)
            begin
                if (stall_left > 0)
                    stall_left--;
                out_stall <= (stall_left > 0);
            end
        end
    end

    // watchdog: count cycles with no beat on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= '0;
        block_sel  <= '0;
        reg_offset <= '0;
        write_data <= '0;
        pin_levels <= '0;
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_map();
        test_edge_interrupts();
        test_random_traffic();
        go_idle();
        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
